### sv/tti_pkg.sv
// Package for the thermistor table interpolator: table constants, types, lookup functions.
// No dependencies.
`timescale 1ns / 1ps
package tti_pkg;
  localparam int StoredLen = 114;
  localparam int TableLenDefault = 114;
  localparam int InW = 24;
  localparam int OutW = 15;
  localparam int TempW = 15;
  localparam int NumW = 48;
  localparam int DenW = 24;
  localparam int QueueDepth = 2;
  localparam logic signed [OutW-1:0] OutMin = -15'sd16384;
  localparam logic signed [OutW-1:0] OutMax = 15'sd16383;

  typedef enum logic [1:0] {FS_IDLE, FS_SCAN, FS_EMIT} front_state_t;
  typedef enum logic [2:0] {BK_IDLE, BK_MUL, BK_LOAD, BK_DIV, BK_OUT} back_state_t;

  // Segment job passed from the search stage to the arithmetic stage.
  typedef struct packed {
    logic                     direct;
    logic [InW-1:0]           ohms;
    logic [InW-1:0]           r_hi;
    logic [InW-1:0]           r_lo;
    logic signed [TempW-1:0]  t_hi;
    logic signed [TempW-1:0]  t_lo;
  } seg_job_t;

  function automatic logic [InW-1:0] ohm_at(input logic [7:0] i);
    logic [InW-1:0] v;
    unique case (i)
      8'd0: v = 24'd3916295; 8'd1: v = 24'd3627711; 8'd2: v = 24'd3362274;
      8'd3: v = 24'd3117987; 8'd4: v = 24'd2893035; 8'd5: v = 24'd2685770;
      8'd6: v = 24'd2494694; 8'd7: v = 24'd2318444; 8'd8: v = 24'd2155781;
      8'd9: v = 24'd2004274; 8'd10: v = 24'd1865595; 8'd11: v = 24'd1737397;
      8'd12: v = 24'd1618827; 8'd13: v = 24'd1509102; 8'd14: v = 24'd1407512;
      8'd15: v = 24'd1313405; 8'd16: v = 24'd1226184; 8'd17: v = 24'd1145306;
      8'd18: v = 24'd1069620; 8'd19: v = 24'd1000019; 8'd20: v = 24'd935383;
      8'd21: v = 24'd875329; 8'd22: v = 24'd819505; 8'd23: v = 24'd767589;
      8'd24: v = 24'd719284; 8'd25: v = 24'd674319; 8'd26: v = 24'd632442;
      8'd27: v = 24'd593086; 8'd28: v = 24'd556739; 8'd29: v = 24'd522842;
      8'd30: v = 24'd491217; 8'd31: v = 24'd461699; 8'd32: v = 24'd434134;
      8'd33: v = 24'd408383; 8'd34: v = 24'd384316; 8'd35: v = 24'd361813;
      8'd36: v = 24'd340581; 8'd37: v = 24'd320895; 8'd38: v = 24'd302466;
      8'd39: v = 24'd285206; 8'd40: v = 24'd269035; 8'd41: v = 24'd253877;
      8'd42: v = 24'd239664; 8'd43: v = 24'd226331; 8'd44: v = 24'd213819;
      8'd45: v = 24'd201971; 8'd46: v = 24'd190946; 8'd47: v = 24'd180588;
      8'd48: v = 24'd170853; 8'd49: v = 24'd161700; 8'd50: v = 24'd153092;
      8'd51: v = 24'd144992; 8'd52: v = 24'd137367; 8'd53: v = 24'd130189;
      8'd54: v = 24'd123368; 8'd55: v = 24'd117000; 8'd56: v = 24'd110998;
      8'd57: v = 24'd105338; 8'd58: v = 24'd100000; 8'd59: v = 24'd94963;
      8'd60: v = 24'd90208; 8'd61: v = 24'd85719; 8'd62: v = 24'd81479;
      8'd63: v = 24'd77438; 8'd64: v = 24'd73654; 8'd65: v = 24'd70076;
      8'd66: v = 24'd66692; 8'd67: v = 24'd63491; 8'd68: v = 24'd60461;
      8'd69: v = 24'd57594; 8'd70: v = 24'd54878; 8'd71: v = 24'd52306;
      8'd72: v = 24'd49847; 8'd73: v = 24'd47538; 8'd74: v = 24'd45349;
      8'd75: v = 24'd43273; 8'd76: v = 24'd41303; 8'd77: v = 24'd39434;
      8'd78: v = 24'd37660; 8'd79: v = 24'd35976; 8'd80: v = 24'd34376;
      8'd81: v = 24'd32843; 8'd82: v = 24'd31399; 8'd83: v = 24'd30027;
      8'd84: v = 24'd28722; 8'd85: v = 24'd27481; 8'd86: v = 24'd26300;
      8'd87: v = 24'd25177; 8'd88: v = 24'd24107; 8'd89: v = 24'd23089;
      8'd90: v = 24'd22111; 8'd91: v = 24'd21188; 8'd92: v = 24'd20308;
      8'd93: v = 24'd19469; 8'd94: v = 24'd18670; 8'd95: v = 24'd17907;
      8'd96: v = 24'd17180; 8'd97: v = 24'd16486; 8'd98: v = 24'd15824;
      8'd99: v = 24'd15187; 8'd100: v = 24'd14584; 8'd101: v = 24'd14008;
      8'd102: v = 24'd13458; 8'd103: v = 24'd12932; 8'd104: v = 24'd12430;
      8'd105: v = 24'd11949; 8'd106: v = 24'd11490; 8'd107: v = 24'd11051;
      8'd108: v = 24'd10627; 8'd109: v = 24'd10225; 8'd110: v = 24'd9841;
      8'd111: v = 24'd9473; 8'd112: v = 24'd9121; 8'd113: v = 24'd8783;
      default: v = 24'd8783;
    endcase
    return v;
  endfunction

  // Temperatures rise by 111 or 112 hundredths per entry from -3944.
  function automatic logic signed [TempW-1:0] temp_at(input logic [7:0] i);
    logic signed [TempW-1:0] v;
    unique case (i)
      8'd0: v = -15'sd3944; 8'd1: v = -15'sd3833; 8'd2: v = -15'sd3722;
      8'd3: v = -15'sd3611; 8'd4: v = -15'sd3500; 8'd5: v = -15'sd3389;
      8'd6: v = -15'sd3278; 8'd7: v = -15'sd3167; 8'd8: v = -15'sd3056;
      8'd9: v = -15'sd2944; 8'd10: v = -15'sd2833; 8'd11: v = -15'sd2722;
      8'd12: v = -15'sd2611; 8'd13: v = -15'sd2500; 8'd14: v = -15'sd2389;
      8'd15: v = -15'sd2278; 8'd16: v = -15'sd2167; 8'd17: v = -15'sd2056;
      8'd18: v = -15'sd1944; 8'd19: v = -15'sd1833; 8'd20: v = -15'sd1722;
      8'd21: v = -15'sd1611; 8'd22: v = -15'sd1500; 8'd23: v = -15'sd1389;
      8'd24: v = -15'sd1278; 8'd25: v = -15'sd1167; 8'd26: v = -15'sd1056;
      8'd27: v = -15'sd944; 8'd28: v = -15'sd833; 8'd29: v = -15'sd722;
      8'd30: v = -15'sd611; 8'd31: v = -15'sd500; 8'd32: v = -15'sd389;
      8'd33: v = -15'sd278; 8'd34: v = -15'sd167; 8'd35: v = -15'sd56;
      8'd36: v = 15'sd56; 8'd37: v = 15'sd167; 8'd38: v = 15'sd278;
      8'd39: v = 15'sd389; 8'd40: v = 15'sd500; 8'd41: v = 15'sd611;
      8'd42: v = 15'sd722; 8'd43: v = 15'sd833; 8'd44: v = 15'sd944;
      8'd45: v = 15'sd1056; 8'd46: v = 15'sd1167; 8'd47: v = 15'sd1278;
      8'd48: v = 15'sd1389; 8'd49: v = 15'sd1500; 8'd50: v = 15'sd1611;
      8'd51: v = 15'sd1722; 8'd52: v = 15'sd1833; 8'd53: v = 15'sd1944;
      8'd54: v = 15'sd2056; 8'd55: v = 15'sd2167; 8'd56: v = 15'sd2278;
      8'd57: v = 15'sd2389; 8'd58: v = 15'sd2500; 8'd59: v = 15'sd2611;
      8'd60: v = 15'sd2722; 8'd61: v = 15'sd2833; 8'd62: v = 15'sd2944;
      8'd63: v = 15'sd3056; 8'd64: v = 15'sd3167; 8'd65: v = 15'sd3278;
      8'd66: v = 15'sd3389; 8'd67: v = 15'sd3500; 8'd68: v = 15'sd3611;
      8'd69: v = 15'sd3722; 8'd70: v = 15'sd3833; 8'd71: v = 15'sd3944;
      8'd72: v = 15'sd4056; 8'd73: v = 15'sd4167; 8'd74: v = 15'sd4278;
      8'd75: v = 15'sd4389; 8'd76: v = 15'sd4500; 8'd77: v = 15'sd4611;
      8'd78: v = 15'sd4722; 8'd79: v = 15'sd4833; 8'd80: v = 15'sd4944;
      8'd81: v = 15'sd5056; 8'd82: v = 15'sd5167; 8'd83: v = 15'sd5278;
      8'd84: v = 15'sd5389; 8'd85: v = 15'sd5500; 8'd86: v = 15'sd5611;
      8'd87: v = 15'sd5722; 8'd88: v = 15'sd5833; 8'd89: v = 15'sd5944;
      8'd90: v = 15'sd6056; 8'd91: v = 15'sd6167; 8'd92: v = 15'sd6278;
      8'd93: v = 15'sd6389; 8'd94: v = 15'sd6500; 8'd95: v = 15'sd6611;
      8'd96: v = 15'sd6722; 8'd97: v = 15'sd6833; 8'd98: v = 15'sd6944;
      8'd99: v = 15'sd7056; 8'd100: v = 15'sd7167; 8'd101: v = 15'sd7278;
      8'd102: v = 15'sd7389; 8'd103: v = 15'sd7500; 8'd104: v = 15'sd7611;
      8'd105: v = 15'sd7722; 8'd106: v = 15'sd7833; 8'd107: v = 15'sd7944;
      8'd108: v = 15'sd8056; 8'd109: v = 15'sd8167; 8'd110: v = 15'sd8278;
      8'd111: v = 15'sd8389; 8'd112: v = 15'sd8500; 8'd113: v = 15'sd8611;
      default: v = 15'sd8611;
    endcase
    return v;
  endfunction
endpackage

### sv/thermistor_table_interpolator.sv
// channel | ports                              | dir
// in      | in_valid/in_ready/in_resistance_ohms | input item, 24-bit ohms
// out     | out_valid/out_ready/out_temperature_centi | result item, 15-bit signed
// Search walks the table one entry a cycle; the divider retires one quotient bit a cycle.
// Items at or above the first entry's resistance skip the divider. Reset clears only
// control state. Either side may stall; a two-entry queue lets search of the next
// item overlap the current divide.
`timescale 1ns / 1ps
module thermistor_table_interpolator #(
  parameter int TABLE_LEN = tti_pkg::TableLenDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tti_pkg::InW-1:0]         in_resistance_ohms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [tti_pkg::OutW-1:0] out_temperature_centi
);
  import tti_pkg::*;

  seg_job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;

  tti_search #(.TABLE_LEN(TABLE_LEN)) u_search (
    .clk, .rst_n, .in_valid, .in_ready, .in_ohms(in_resistance_ohms),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

  tti_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_job(b_job));

  tti_interp u_interp (
    .clk, .rst_n, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid, .out_ready, .out_temp(out_temperature_centi));
endmodule

### sv/tti_search.sv
// Front end: accepts an item and walks the resistance table one entry a cycle.
// Depends on tti_pkg.
`timescale 1ns / 1ps
module tti_search #(
  parameter int TABLE_LEN = tti_pkg::TableLenDefault
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tti_pkg::InW-1:0]   in_ohms,
  output logic                      job_valid,
  input  logic                      job_ready,
  output tti_pkg::seg_job_t         job
);
  import tti_pkg::*;

  localparam int UsedLen = (TABLE_LEN > StoredLen) ? StoredLen :
                           ((TABLE_LEN < 2) ? 2 : TABLE_LEN);
  localparam logic [7:0] LastIdx = 8'(UsedLen - 1);

  front_state_t   state_r, state_nxt;
  logic [7:0]     idx_r, idx_nxt;
  logic [InW-1:0] ohms_r;
  logic [InW-1:0] cur_ohm;

  assign cur_ohm = ohm_at(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) ohms_r <= in_ohms;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    in_ready  = 1'b0;
    job_valid = 1'b0;
    unique case (state_r)
      FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = FS_SCAN;
          idx_nxt   = '0;
        end
      end
      FS_SCAN: begin
        if (idx_r != LastIdx && cur_ohm > ohms_r) idx_nxt = idx_r + 8'd1;
        else state_nxt = FS_EMIT;
      end
      FS_EMIT: begin
        job_valid = 1'b1;
        if (job_ready) state_nxt = FS_IDLE;
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    job.direct = (idx_r == '0);
    job.ohms   = ohms_r;
    job.r_lo   = ohm_at(idx_r);
    job.t_lo   = temp_at(idx_r);
    job.r_hi   = ohm_at(idx_r - 8'd1);
    job.t_hi   = temp_at(idx_r - 8'd1);
  end
endmodule

### sv/tti_queue.sv
// Two-entry queue of segment jobs between search and arithmetic.
// Depends on tti_pkg.
`timescale 1ns / 1ps
module tti_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  tti_pkg::seg_job_t wr_job,
  output logic              rd_valid,
  input  logic              rd_ready,
  output tti_pkg::seg_job_t rd_job
);
  import tti_pkg::*;

  seg_job_t  mem_r [QueueDepth];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic      wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'(QueueDepth));
  assign rd_valid = (cnt_r != '0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_job;
  end
endmodule

### sv/tti_interp.sv
// Back end: forms numerator, runs a restoring divider, saturates and holds the item.
// Depends on tti_pkg.
`timescale 1ns / 1ps
module tti_interp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  tti_pkg::seg_job_t             job,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [tti_pkg::OutW-1:0] out_temp
);
  import tti_pkg::*;

  localparam int ProdW = InW + 1 + TempW;

  back_state_t state_r, state_nxt;
  logic [5:0]              cnt_r;
  logic [NumW-1:0]         quo_r;     // magnitude of numerator, shifts into quotient
  logic [DenW:0]           rem_r;
  logic [DenW-1:0]         den_r;
  logic                    neg_r;
  logic signed [NumW-1:0]  num_r;
  logic signed [OutW-1:0]  res_r;
  logic signed [TempW-1:0] dtemp_r;
  logic signed [InW:0]     dohm_r;
  logic signed [TempW-1:0] tlo_r;
  logic                    direct_r;

  logic [DenW:0]           trial;
  logic signed [NumW-1:0]  qs;
  logic signed [ProdW-1:0] prod_a, prod_b;

  assign trial  = {rem_r[DenW-1:0], quo_r[NumW-1]} - {1'b0, den_r};
  assign qs     = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign prod_a = ProdW'(dohm_r) * ProdW'(dtemp_r);
  assign prod_b = ProdW'(tlo_r) * ProdW'($signed({1'b0, den_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    job_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) state_nxt = BK_MUL;
      end
      BK_MUL:  state_nxt = direct_r ? BK_OUT : BK_LOAD;
      BK_LOAD: state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == 6'(NumW)) state_nxt = BK_OUT;
      BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: if (job_valid) begin
        den_r    <= job.r_hi - job.r_lo;
        dtemp_r  <= job.t_hi - job.t_lo;
        dohm_r   <= $signed({1'b0, job.ohms}) - $signed({1'b0, job.r_lo});
        tlo_r    <= job.t_lo;
        direct_r <= job.direct;
        res_r    <= job.t_lo;
      end
      BK_MUL: begin
        num_r <= NumW'(prod_a) + NumW'(prod_b);
      end
      BK_LOAD: begin
        // divide the magnitude, sign is put back at the end (truncates toward zero)
        neg_r <= num_r[NumW-1];
        quo_r <= num_r[NumW-1] ? $unsigned(-num_r) : $unsigned(num_r);
        cnt_r <= '0;
        rem_r <= '0;
      end
      BK_DIV: begin
        cnt_r <= cnt_r + 6'd1;
        if (trial[DenW]) begin
          rem_r <= {rem_r[DenW-1:0], quo_r[NumW-1]};
          quo_r <= {quo_r[NumW-2:0], 1'b0};
        end else begin
          rem_r <= trial;
          quo_r <= {quo_r[NumW-2:0], 1'b1};
        end
        if (cnt_r == 6'(NumW)) begin
          if (qs < NumW'(OutMin))      res_r <= OutMin;
          else if (qs > NumW'(OutMax)) res_r <= OutMax;
          else                         res_r <= qs[OutW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign out_temp = res_r;
endmodule

### sv/tti_checker.sv
// Port-level checker for the thermistor table interpolator, bound to the top level.
// Depends on tti_pkg.
`timescale 1ns / 1ps
module tti_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [tti_pkg::OutW-1:0] out_temperature_centi
);
  import tti_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_temperature_centi))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temperature_centi >= -15'sd3944)
    else $error("result below table floor");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("search took a second item at once");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind thermistor_table_interpolator tti_checker u_tti_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_temperature_centi);
